// ----- rtl/dqem_pkg.sv -----
// Shared types and constants for the dual quadrature encoder monitor.
`default_nettype none

package dqem_pkg;

    localparam int FRAME_LEN = 14;
    localparam int FRAME_CNT_W = $clog2(FRAME_LEN + 1);
    localparam int POS_W = 16;
    localparam int TICK_W = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0] HASH_BYTE = 8'h23;
    localparam logic [TICK_W-1:0] WINDOW_RESET = 8'd64;
    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW = 3'd0;

    typedef enum logic [1:0] {
        CMD_LEFT_EDGE  = 2'd0,
        CMD_RIGHT_EDGE = 2'd1,
        CMD_TICK       = 2'd2,
        CMD_RX_PAIR    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic             direction;
        logic             borrow;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] pulses;
    } t_chan;

    typedef struct packed {
        logic step;
        logic phase_b;
        logic clear_pulses;
        logic clear_position;
    } t_chan_ctrl;

    typedef logic [FRAME_LEN-1:0][7:0] t_frame;

endpackage

`default_nettype wire

// ----- rtl/dqem_encoder.sv -----
// One encoder channel: direction, position with borrow flag, pulse count.
`default_nettype none

module dqem_encoder
    import dqem_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire t_chan_ctrl i_ctrl,
    output t_chan           o_status
);

    t_chan r_chan;
    t_chan n_chan;

    always_comb begin
        n_chan = r_chan;
        if (i_ctrl.step) begin
            // drop the pulse count when the direction turns
            if (r_chan.direction != i_ctrl.phase_b) begin
                n_chan.pulses = '0;
            end else begin
                n_chan.pulses = r_chan.pulses + POS_W'(1);
            end
            n_chan.direction = i_ctrl.phase_b;
            if (i_ctrl.phase_b) begin
                if (r_chan.position == {POS_W{1'b1}}) begin
                    n_chan.borrow = 1'b0;
                end
                n_chan.position = r_chan.position + POS_W'(1);
            end else begin
                if (r_chan.position == '0) begin
                    n_chan.borrow = 1'b1;
                end
                n_chan.position = r_chan.position - POS_W'(1);
            end
        end
        if (i_ctrl.clear_pulses) begin
            n_chan.pulses = '0;
        end
        if (i_ctrl.clear_position) begin
            n_chan.position = '0;
            n_chan.borrow   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
        end else begin
            r_chan <= n_chan;
        end
    end

    assign o_status = r_chan;

endmodule

`default_nettype wire

// ----- rtl/dqem_frame.sv -----
// Status frame buffer and byte serializer with output register.
`default_nettype none

module dqem_frame
    import dqem_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_load,
    input  wire t_frame i_frame,
    input  wire         i_stall,
    output logic        o_busy,
    output logic        o_valid,
    output logic [7:0]  o_byte,
    output logic        o_last
);

    t_frame                 r_frame;
    logic [FRAME_CNT_W-1:0] r_left;
    logic                   r_valid;
    logic [7:0]             r_byte;
    logic                   r_last;
    logic                   w_move;

    // advance when a byte is pending and the output register is free
    assign w_move = (r_left != '0) && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_left <= FRAME_CNT_W'(FRAME_LEN);
            end else if (w_move) begin
                r_left <= r_left - FRAME_CNT_W'(1);
            end
            if (w_move) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame <= i_frame;
        end else if (w_move) begin
            r_frame <= {8'h00, r_frame[FRAME_LEN-1:1]};
        end
        if (w_move) begin
            r_byte <= r_frame[0];
            r_last <= (r_left == FRAME_CNT_W'(1));
        end
    end

    assign o_busy  = (r_left != '0);
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

`default_nettype wire

// ----- rtl/dual_quadrature_encoder_monitor_core.sv -----
// Top level of the dual quadrature encoder monitor.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------------
//  input    | i_in_valid / o_in_stall      | i_cmd, i_phase_b, i_rx_first, i_rx_second,
//           |                              | i_lidar_fields, i_buttons, i_battery_a/b
//  output   | o_out_valid / i_out_stall    | o_frame_byte, o_last_byte
//  config   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// Edge, tick and other items update state at the edge that accepts them: one item a cycle,
// unless stalled. A '##' pair captures the 14-byte frame; the serializer, when not stalled,
// sends one byte a cycle, and o_in_stall stays high until the last byte has moved into the
// output register. Synchronous active-low reset clears all counters, flags and the frame
// buffer control. i_out_stall holds the current byte; the serializer waits behind it.
`default_nettype none

module dual_quadrature_encoder_monitor_core
    import dqem_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire  [1:0]            i_cmd,
    input  wire                   i_phase_b,
    input  wire  [7:0]            i_rx_first,
    input  wire  [7:0]            i_rx_second,
    input  wire  [3:0]            i_lidar_fields,
    input  wire  [3:0]            i_buttons,
    input  wire  [11:0]           i_battery_a,
    input  wire  [11:0]           i_battery_b,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic [7:0]            o_frame_byte,
    output logic                  o_last_byte,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [APB_ADDR_W-1:0] paddr,
    input  wire  [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [TICK_W-1:0] r_window;
    logic [TICK_W-1:0] r_tick;
    logic [TICK_W-1:0] n_tick;
    logic [POS_W-1:0]  r_left_speed;
    logic [POS_W-1:0]  r_right_speed;

    t_cmd       w_cmd;
    logic       w_accept;
    logic       w_tick;
    logic       w_window_end;
    logic       w_frame;
    logic       w_busy;
    t_chan_ctrl w_left_ctrl;
    t_chan_ctrl w_right_ctrl;
    t_chan      w_left;
    t_chan      w_right;
    t_frame     w_frame_bytes;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_WINDOW) begin
            r_window <= pwdata[TICK_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_WINDOW) begin
            prdata = APB_DATA_W'(r_window);
        end
    end

    assign o_in_stall = w_busy;
    assign w_accept   = i_in_valid && !w_busy;
    assign w_cmd      = t_cmd'(i_cmd);
    assign w_tick     = w_accept && (w_cmd == CMD_TICK);
    assign n_tick     = r_tick + TICK_W'(1);
    assign w_window_end = w_tick && (n_tick == r_window);
    assign w_frame    = w_accept && (w_cmd == CMD_RX_PAIR)
                        && (i_rx_first == HASH_BYTE) && (i_rx_second == HASH_BYTE);

    always_comb begin
        w_left_ctrl.step           = w_accept && (w_cmd == CMD_LEFT_EDGE);
        w_left_ctrl.phase_b        = i_phase_b;
        w_left_ctrl.clear_pulses   = w_window_end;
        w_left_ctrl.clear_position = w_frame;
        w_right_ctrl.step           = w_accept && (w_cmd == CMD_RIGHT_EDGE);
        w_right_ctrl.phase_b        = i_phase_b;
        w_right_ctrl.clear_pulses   = w_window_end;
        w_right_ctrl.clear_position = w_frame;
    end

    dqem_encoder u_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_left_ctrl),
        .o_status (w_left)
    );

    dqem_encoder u_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_right_ctrl),
        .o_status (w_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick        <= '0;
            r_left_speed  <= '0;
            r_right_speed <= '0;
        end else if (w_tick) begin
            if (w_window_end) begin
                r_tick        <= '0;
                r_left_speed  <= w_left.pulses;
                r_right_speed <= w_right.pulses;
            end else begin
                r_tick <= n_tick;
            end
        end
    end

    always_comb begin
        w_frame_bytes[0]  = {2'b00, i_buttons[1], i_buttons[0], i_lidar_fields[1],
                             i_lidar_fields[0], w_left.borrow, w_left.direction};
        w_frame_bytes[1]  = {2'b00, i_buttons[3], i_buttons[2], i_lidar_fields[3],
                             i_lidar_fields[2], w_right.borrow, w_right.direction};
        w_frame_bytes[2]  = r_left_speed[15:8];
        w_frame_bytes[3]  = r_left_speed[7:0];
        w_frame_bytes[4]  = r_right_speed[15:8];
        w_frame_bytes[5]  = r_right_speed[7:0];
        w_frame_bytes[6]  = w_left.position[7:0];
        w_frame_bytes[7]  = w_left.position[15:8];
        w_frame_bytes[8]  = w_right.position[7:0];
        w_frame_bytes[9]  = w_right.position[15:8];
        w_frame_bytes[10] = i_battery_a[7:0];
        w_frame_bytes[11] = {4'h0, i_battery_a[11:8]};
        w_frame_bytes[12] = i_battery_b[7:0];
        w_frame_bytes[13] = {4'h0, i_battery_b[11:8]};
    end

    dqem_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_frame),
        .i_frame (w_frame_bytes),
        .i_stall (i_out_stall),
        .o_busy  (w_busy),
        .o_valid (o_out_valid),
        .o_byte  (o_frame_byte),
        .o_last  (o_last_byte)
    );

    a_frame_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_frame |=> o_in_stall)
        else $error("frame request did not block input");

    a_frame_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_frame |=> (w_left.position == '0 && w_right.position == '0
                     && !w_left.borrow && !w_right.borrow))
        else $error("positions not cleared after frame");

    a_left_dir_follows_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_left_ctrl.step |=> (w_left.direction == $past(i_phase_b)))
        else $error("left direction does not follow B level");

    a_window_clears_pulses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_window_end |=> (r_tick == '0 && w_left.pulses == '0 && w_right.pulses == '0))
        else $error("window end did not clear pulse counts");

endmodule

`default_nettype wire
